@@ src/lpia_pkg.sv @@
package lpia_pkg;

	// result word widths
	localparam int OUT_W = 24;
	localparam int ANG_OUT_W = 16;
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	// ray from the saturated crossing to an end point: |value| < 2^25 over the whole
	// coordinate and fraction range
	localparam int RAY_W = 26;
	localparam int PROD_W = 2 * RAY_W;
	localparam int MAG_W = PROD_W + 1;

	// cordic datapath
	localparam int CORDIC_STEPS = 23;
	localparam int NORM_BIT = 49;
	localparam int CX_W = MAG_W + 2;
	localparam int Z_W = 25;
	localparam int ANG_FRAC = 16;
	localparam int ATAN_W = 22;
	localparam int ANG_Q_W = 23;
	localparam int ANG_FULL_W = 24;
	localparam int ANG_ROUND_SH = ANG_FRAC - 8;
	localparam int RIGHT_DEG = 90;
	localparam int HALF_TURN_DEG = 180;
	localparam logic [ANG_Q_W-1:0] RIGHT_Q = ANG_Q_W'(RIGHT_DEG << ANG_FRAC);
	localparam logic [ANG_FULL_W-1:0] HALF_TURN_Q = ANG_FULL_W'(HALF_TURN_DEG << ANG_FRAC);
	localparam logic [ANG_FULL_W-1:0] ANG_ROUND = ANG_FULL_W'(1 << (ANG_ROUND_SH - 1));

	// atan(2^-i) in degrees, 16 fraction bits
	localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
		22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2, 22'd1
	};

	// latencies of the two units
	localparam int DIV_LAT = OUT_W + 2;
	localparam int COR_LAT = CORDIC_STEPS + 3;

endpackage

@@ src/lpia_div.sv @@
module lpia_div #(
	parameter int NW = 47,
	parameter int DW = 28
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic neg,
	output logic out_vld,
	output logic signed [lpia_pkg::OUT_W-1:0] quo
);

	localparam int QB = lpia_pkg::OUT_W;
	localparam int W = (NW > DW + QB) ? NW : DW + QB;

	logic [W-1:0] rem_s [0:QB];
	logic [DW-1:0] den_s [0:QB];
	logic [QB-1:0] q_s [0:QB];
	logic ovf_s [0:QB];
	logic neg_s [0:QB];
	logic vl_s [0:QB];
	logic signed [QB-1:0] quo_q;
	logic vld_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) vl_s[k] <= 1'b0;
			vld_q <= 1'b0;
		end else if (en) begin
			vl_s[0] <= in_vld;
			for (int k = 1; k <= QB; k++) vl_s[k] <= vl_s[k-1];
			vld_q <= vl_s[QB];
		end
	end

	// entry: a quotient too wide for the QB quotient bits is caught up front
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= W'(num);
			den_s[0] <= den;
			q_s[0] <= '0;
			ovf_s[0] <= W'(num) >= (W'(den) << QB);
			neg_s[0] <= neg;
		end
	end

	// one restoring quotient bit per stage, msb first
	for (genvar j = 0; j < QB; j++) begin : g_bit
		localparam int B = QB - 1 - j;
		logic [W-1:0] sub;
		logic ge;
		assign sub = W'(den_s[j]) << B;
		assign ge = rem_s[j] >= sub;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? rem_s[j] - sub : rem_s[j];
				den_s[j+1] <= den_s[j];
				q_s[j+1] <= q_s[j] | (QB'(ge) << B);
				ovf_s[j+1] <= ovf_s[j];
				neg_s[j+1] <= neg_s[j];
			end
		end
	end

	// sign and saturation
	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf_s[QB]) begin
				quo_q <= neg_s[QB] ? lpia_pkg::OUT_MIN : lpia_pkg::OUT_MAX;
			end else if (neg_s[QB]) begin
				quo_q <= (q_s[QB][QB-1] && (q_s[QB][QB-2:0] != '0)) ?
					lpia_pkg::OUT_MIN : -$signed(q_s[QB]);
			end else begin
				quo_q <= q_s[QB][QB-1] ? lpia_pkg::OUT_MAX : $signed(q_s[QB]);
			end
		end
	end

	assign out_vld = vld_q;
	assign quo = quo_q;

endmodule

@@ src/lpia_cordic.sv @@
module lpia_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  logic [lpia_pkg::MAG_W-1:0] xin,
	input  logic [lpia_pkg::MAG_W-1:0] yin,
	output logic out_vld,
	output logic [lpia_pkg::ANG_Q_W-1:0] ang
);

	localparam int IW = lpia_pkg::MAG_W;
	localparam int XW = lpia_pkg::CX_W;
	localparam int ZW = lpia_pkg::Z_W;
	localparam int NS = lpia_pkg::CORDIC_STEPS;
	localparam int NB = lpia_pkg::NORM_BIT;

	logic [IW-1:0] xa, ya, xb, yb;
	logic [IW-1:0] xn_s1, yn_s1;
	logic vn_s1;
	logic signed [XW-1:0] xr_s [0:NS];
	logic signed [XW-1:0] yr_s [0:NS];
	logic signed [ZW-1:0] zr_s [0:NS];
	logic vl_s [0:NS];
	logic [lpia_pkg::ANG_Q_W-1:0] ang_q;
	logic vld_q;

	// normalize, coarse shifts
	always_comb begin
		xa = xin;
		ya = yin;
		if ((xa | ya) < (IW'(1) << (NB - 32))) begin
			xa = xa << 32;
			ya = ya << 32;
		end
		if ((xa | ya) < (IW'(1) << (NB - 16))) begin
			xa = xa << 16;
			ya = ya << 16;
		end
		if ((xa | ya) < (IW'(1) << (NB - 8))) begin
			xa = xa << 8;
			ya = ya << 8;
		end
	end

	// normalize, fine shifts, then one more until the top bit is reached
	always_comb begin
		xb = xn_s1;
		yb = yn_s1;
		if ((xb | yb) < (IW'(1) << (NB - 4))) begin
			xb = xb << 4;
			yb = yb << 4;
		end
		if ((xb | yb) < (IW'(1) << (NB - 2))) begin
			xb = xb << 2;
			yb = yb << 2;
		end
		if ((xb | yb) < (IW'(1) << (NB - 1))) begin
			xb = xb << 1;
			yb = yb << 1;
		end
		if ((xb | yb) < (IW'(1) << NB)) begin
			xb = xb << 1;
			yb = yb << 1;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vn_s1 <= 1'b0;
			for (int k = 0; k <= NS; k++) vl_s[k] <= 1'b0;
			vld_q <= 1'b0;
		end else if (en) begin
			vn_s1 <= in_vld;
			vl_s[0] <= vn_s1;
			for (int k = 1; k <= NS; k++) vl_s[k] <= vl_s[k-1];
			vld_q <= vl_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xn_s1 <= xa;
			yn_s1 <= ya;
			xr_s[0] <= $signed(XW'(xb));
			yr_s[0] <= $signed(XW'(yb));
			zr_s[0] <= '0;
		end
	end

	// vectoring rotations, one per stage
	for (genvar i = 0; i < NS; i++) begin : g_rot
		logic signed [XW-1:0] shx, shy;
		logic signed [ZW-1:0] at;
		logic pos;
		assign shy = yr_s[i] >>> i;
		assign shx = xr_s[i] >>> i;
		assign at = $signed(ZW'(lpia_pkg::ATAN_TAB[i]));
		assign pos = !yr_s[i][XW-1] && (yr_s[i] != '0);
		always_ff @(posedge clk) begin
			if (en) begin
				if (pos) begin
					xr_s[i+1] <= xr_s[i] + shy;
					yr_s[i+1] <= yr_s[i] - shx;
					zr_s[i+1] <= zr_s[i] + at;
				end else begin
					xr_s[i+1] <= xr_s[i] - shy;
					yr_s[i+1] <= yr_s[i] + shx;
					zr_s[i+1] <= zr_s[i] - at;
				end
			end
		end
	end

	// clamp to a quarter turn
	always_ff @(posedge clk) begin
		if (en) begin
			if (zr_s[NS][ZW-1]) begin
				ang_q <= '0;
			end else if (zr_s[NS] > $signed(ZW'(lpia_pkg::RIGHT_Q))) begin
				ang_q <= lpia_pkg::RIGHT_Q;
			end else begin
				ang_q <= lpia_pkg::ANG_Q_W'(zr_s[NS]);
			end
		end
	end

	assign out_vld = vld_q;
	assign ang = ang_q;

endmodule

@@ src/line_pair_intersection_angle.sv @@
// channel  direction  handshake            payload
// in       input      in_valid / in_ready  first_* and second_* end point coordinates
// out      output     out_valid/out_ready  crosses, cross_x, cross_y, angle_deg, angle_valid
//
// one word per cycle sustained while out_ready does not hold the output word
// most of the latency comes from the 24-bit restoring divider and the 23-step cordic, one step a stage
// every stage moves on a single enable; a held output word freezes the whole pipe
// arst_n clears only the valid bits
module line_pair_intersection_angle #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [COORD_BITS-1:0] first_start_x,
	input  logic [COORD_BITS-1:0] first_start_y,
	input  logic [COORD_BITS-1:0] first_end_x,
	input  logic [COORD_BITS-1:0] first_end_y,
	input  logic [COORD_BITS-1:0] second_start_x,
	input  logic [COORD_BITS-1:0] second_start_y,
	input  logic [COORD_BITS-1:0] second_end_x,
	input  logic [COORD_BITS-1:0] second_end_y,
	output logic out_valid,
	input  logic out_ready,
	output logic crosses,
	output logic signed [lpia_pkg::OUT_W-1:0] cross_x,
	output logic signed [lpia_pkg::OUT_W-1:0] cross_y,
	output logic [lpia_pkg::ANG_OUT_W-1:0] angle_deg,
	output logic angle_valid
);

	localparam int CB = COORD_BITS;
	localparam int PW = 2 * CB + 3;
	localparam int DETW = 2 * CB + 3;
	localparam int MW = 3 * CB + 4;
	localparam int NUMW = 3 * CB + 5;
	localparam int NW = NUMW + FRAC_BITS + 2;
	localparam int DW = DETW + 1;
	localparam int OW = lpia_pkg::OUT_W;
	localparam int RW = lpia_pkg::RAY_W;
	localparam int PRW = lpia_pkg::PROD_W;
	localparam int MGW = lpia_pkg::MAG_W;
	localparam int DL = lpia_pkg::DIV_LAT;
	localparam int CL = lpia_pkg::COR_LAT;
	localparam int AFW = lpia_pkg::ANG_FULL_W;

	logic en;

	// stage 1
	logic signed [CB:0] ddx1, ddy1, ddx2, ddy2;
	logic signed [CB:0] dx1_s1, dy1_s1, dx2_s1, dy2_s1;
	logic signed [PW-1:0] p1_s1, q1_s1, p2_s1, q2_s1;
	logic [CB-1:0] ex1_s1, ey1_s1, ex2_s1, ey2_s1;
	logic vld_s1;
	// stage 2
	logic signed [CB:0] dx1_s2, dy1_s2, dx2_s2, dy2_s2;
	logic signed [PW-1:0] c1_s2, c2_s2;
	logic signed [DETW-1:0] dtp_s2, dtq_s2;
	logic [CB-1:0] ex1_s2, ey1_s2, ex2_s2, ey2_s2;
	logic vld_s2;
	// stage 3
	logic signed [DETW-1:0] det_s3;
	logic signed [MW-1:0] mxa_s3, mxb_s3, mya_s3, myb_s3;
	logic [CB-1:0] ex1_s3, ey1_s3, ex2_s3, ey2_s3;
	logic vld_s3;
	// stage 4
	logic signed [DETW-1:0] det_s4;
	logic signed [NUMW-1:0] numx_s4, numy_s4;
	logic [CB-1:0] ex1_s4, ey1_s4, ex2_s4, ey2_s4;
	logic vld_s4;
	// stage 5
	logic [NUMW-1:0] mnx, mny;
	logic [DETW-1:0] mdet;
	logic [NW-1:0] nx_s5, ny_s5;
	logic [DW-1:0] dd_s5;
	logic negx_s5, negy_s5, cr_s5;
	logic [CB-1:0] ex1_s5, ey1_s5, ex2_s5, ey2_s5;
	logic vld_s5;
	// divider and its side line
	logic dvx_vld, dvy_vld;
	logic signed [OW-1:0] dvx, dvy;
	logic cr_dl_s [0:DL-1];
	logic [CB-1:0] ex1_dl_s [0:DL-1];
	logic [CB-1:0] ey1_dl_s [0:DL-1];
	logic [CB-1:0] ex2_dl_s [0:DL-1];
	logic [CB-1:0] ey2_dl_s [0:DL-1];
	// stage 32
	logic signed [RW-1:0] ux_s32, uy_s32, vx_s32, vy_s32;
	logic signed [OW-1:0] cx_s32, cy_s32;
	logic cr_s32, vld_s32;
	// stage 33
	logic signed [PRW-1:0] pdx_s33, pdy_s33, pcx_s33, pcy_s33;
	logic signed [OW-1:0] cx_s33, cy_s33;
	logic cr_s33, av_s33, vld_s33;
	// stage 34
	logic signed [MGW-1:0] dot_s34, crs_s34;
	logic signed [OW-1:0] cx_s34, cy_s34;
	logic cr_s34, av_s34, vld_s34;
	// stage 35
	logic [MGW-1:0] dmag_s35, cmag_s35;
	logic signed [OW-1:0] cx_s35, cy_s35;
	logic cr_s35, av_s35, dn_s35, vld_s35;
	// cordic and its side line
	logic cor_vld;
	logic [lpia_pkg::ANG_Q_W-1:0] cor_ang;
	logic cr_cl_s [0:CL-1];
	logic av_cl_s [0:CL-1];
	logic dn_cl_s [0:CL-1];
	logic signed [OW-1:0] cx_cl_s [0:CL-1];
	logic signed [OW-1:0] cy_cl_s [0:CL-1];
	// output stage
	logic [AFW-1:0] ang_full, ang_rnd;
	logic signed [OW-1:0] cx_s62, cy_s62;
	logic [lpia_pkg::ANG_OUT_W-1:0] ang_s62;
	logic cr_s62, av_s62, vld_s62;

	// one enable for the whole pipe
	assign en = !vld_s62 || out_ready;
	assign in_ready = en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s32 <= 1'b0;
			vld_s33 <= 1'b0;
			vld_s34 <= 1'b0;
			vld_s35 <= 1'b0;
			vld_s62 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s32 <= dvx_vld && dvy_vld;
			vld_s33 <= vld_s32;
			vld_s34 <= vld_s33;
			vld_s35 <= vld_s34;
			vld_s62 <= cor_vld;
		end
	end

	// segment deltas
	assign ddx1 = $signed({1'b0, first_end_x}) - $signed({1'b0, first_start_x});
	assign ddy1 = $signed({1'b0, first_end_y}) - $signed({1'b0, first_start_y});
	assign ddx2 = $signed({1'b0, second_end_x}) - $signed({1'b0, second_start_x});
	assign ddy2 = $signed({1'b0, second_end_y}) - $signed({1'b0, second_start_y});

	// line coefficients, determinant and crossing numerators
	always_ff @(posedge clk) begin
		if (en) begin
			dx1_s1 <= ddx1;
			dy1_s1 <= ddy1;
			dx2_s1 <= ddx2;
			dy2_s1 <= ddy2;
			p1_s1 <= PW'(ddy1) * PW'($signed({1'b0, first_start_x}));
			q1_s1 <= PW'(ddx1) * PW'($signed({1'b0, first_start_y}));
			p2_s1 <= PW'(ddy2) * PW'($signed({1'b0, second_start_x}));
			q2_s1 <= PW'(ddx2) * PW'($signed({1'b0, second_start_y}));
			ex1_s1 <= first_end_x;
			ey1_s1 <= first_end_y;
			ex2_s1 <= second_end_x;
			ey2_s1 <= second_end_y;

			dx1_s2 <= dx1_s1;
			dy1_s2 <= dy1_s1;
			dx2_s2 <= dx2_s1;
			dy2_s2 <= dy2_s1;
			c1_s2 <= p1_s1 - q1_s1;
			c2_s2 <= p2_s1 - q2_s1;
			dtp_s2 <= DETW'(dy2_s1) * DETW'(dx1_s1);
			dtq_s2 <= DETW'(dy1_s1) * DETW'(dx2_s1);
			ex1_s2 <= ex1_s1;
			ey1_s2 <= ey1_s1;
			ex2_s2 <= ex2_s1;
			ey2_s2 <= ey2_s1;

			det_s3 <= dtp_s2 - dtq_s2;
			mxa_s3 <= MW'(dx1_s2) * MW'(c2_s2);
			mxb_s3 <= MW'(dx2_s2) * MW'(c1_s2);
			mya_s3 <= MW'(dy1_s2) * MW'(c2_s2);
			myb_s3 <= MW'(dy2_s2) * MW'(c1_s2);
			ex1_s3 <= ex1_s2;
			ey1_s3 <= ey1_s2;
			ex2_s3 <= ex2_s2;
			ey2_s3 <= ey2_s2;

			det_s4 <= det_s3;
			numx_s4 <= NUMW'(mxa_s3) - NUMW'(mxb_s3);
			numy_s4 <= NUMW'(mya_s3) - NUMW'(myb_s3);
			ex1_s4 <= ex1_s3;
			ey1_s4 <= ey1_s3;
			ex2_s4 <= ex2_s3;
			ey2_s4 <= ey2_s3;
		end
	end

	// magnitudes and the rounded dividend
	assign mnx = numx_s4[NUMW-1] ? -numx_s4 : numx_s4;
	assign mny = numy_s4[NUMW-1] ? -numy_s4 : numy_s4;
	assign mdet = det_s4[DETW-1] ? -det_s4 : det_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s5 <= (NW'(mnx) << (FRAC_BITS + 1)) + NW'(mdet);
			ny_s5 <= (NW'(mny) << (FRAC_BITS + 1)) + NW'(mdet);
			dd_s5 <= {mdet, 1'b0};
			negx_s5 <= numx_s4[NUMW-1] ^ det_s4[DETW-1];
			negy_s5 <= numy_s4[NUMW-1] ^ det_s4[DETW-1];
			cr_s5 <= det_s4 != '0;
			ex1_s5 <= ex1_s4;
			ey1_s5 <= ey1_s4;
			ex2_s5 <= ex2_s4;
			ey2_s5 <= ey2_s4;
		end
	end

	lpia_div #(.NW(NW), .DW(DW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s5),
		.num(nx_s5), .den(dd_s5), .neg(negx_s5),
		.out_vld(dvx_vld), .quo(dvx)
	);

	lpia_div #(.NW(NW), .DW(DW)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s5),
		.num(ny_s5), .den(dd_s5), .neg(negy_s5),
		.out_vld(dvy_vld), .quo(dvy)
	);

	// the crossing flag and end points ride alongside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			cr_dl_s[0] <= cr_s5;
			ex1_dl_s[0] <= ex1_s5;
			ey1_dl_s[0] <= ey1_s5;
			ex2_dl_s[0] <= ex2_s5;
			ey2_dl_s[0] <= ey2_s5;
			for (int k = 1; k < DL; k++) begin
				cr_dl_s[k] <= cr_dl_s[k-1];
				ex1_dl_s[k] <= ex1_dl_s[k-1];
				ey1_dl_s[k] <= ey1_dl_s[k-1];
				ex2_dl_s[k] <= ex2_dl_s[k-1];
				ey2_dl_s[k] <= ey2_dl_s[k-1];
			end
		end
	end

	// rays from the crossing to the end points, then dot and cross products
	always_ff @(posedge clk) begin
		if (en) begin
			ux_s32 <= $signed(RW'(ex1_dl_s[DL-1]) << FRAC_BITS) - RW'(dvx);
			uy_s32 <= $signed(RW'(ey1_dl_s[DL-1]) << FRAC_BITS) - RW'(dvy);
			vx_s32 <= $signed(RW'(ex2_dl_s[DL-1]) << FRAC_BITS) - RW'(dvx);
			vy_s32 <= $signed(RW'(ey2_dl_s[DL-1]) << FRAC_BITS) - RW'(dvy);
			cx_s32 <= dvx;
			cy_s32 <= dvy;
			cr_s32 <= cr_dl_s[DL-1];

			pdx_s33 <= PRW'(ux_s32) * PRW'(vx_s32);
			pdy_s33 <= PRW'(uy_s32) * PRW'(vy_s32);
			pcx_s33 <= PRW'(ux_s32) * PRW'(vy_s32);
			pcy_s33 <= PRW'(uy_s32) * PRW'(vx_s32);
			av_s33 <= cr_s32 && !(ux_s32 == '0 && uy_s32 == '0)
				&& !(vx_s32 == '0 && vy_s32 == '0);
			cx_s33 <= cx_s32;
			cy_s33 <= cy_s32;
			cr_s33 <= cr_s32;

			dot_s34 <= MGW'(pdx_s33) + MGW'(pdy_s33);
			crs_s34 <= MGW'(pcx_s33) - MGW'(pcy_s33);
			cx_s34 <= cx_s33;
			cy_s34 <= cy_s33;
			cr_s34 <= cr_s33;
			av_s34 <= av_s33;

			dmag_s35 <= dot_s34[MGW-1] ? -dot_s34 : dot_s34;
			cmag_s35 <= crs_s34[MGW-1] ? -crs_s34 : crs_s34;
			dn_s35 <= dot_s34[MGW-1];
			cx_s35 <= cx_s34;
			cy_s35 <= cy_s34;
			cr_s35 <= cr_s34;
			av_s35 <= av_s34;
		end
	end

	lpia_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s35),
		.xin(dmag_s35), .yin(cmag_s35),
		.out_vld(cor_vld), .ang(cor_ang)
	);

	// flags and crossing ride alongside the cordic
	always_ff @(posedge clk) begin
		if (en) begin
			cr_cl_s[0] <= cr_s35;
			av_cl_s[0] <= av_s35;
			dn_cl_s[0] <= dn_s35;
			cx_cl_s[0] <= cx_s35;
			cy_cl_s[0] <= cy_s35;
			for (int k = 1; k < CL; k++) begin
				cr_cl_s[k] <= cr_cl_s[k-1];
				av_cl_s[k] <= av_cl_s[k-1];
				dn_cl_s[k] <= dn_cl_s[k-1];
				cx_cl_s[k] <= cx_cl_s[k-1];
				cy_cl_s[k] <= cy_cl_s[k-1];
			end
		end
	end

	// obtuse fold and rounding to Q8.8
	assign ang_full = dn_cl_s[CL-1] ? lpia_pkg::HALF_TURN_Q - AFW'(cor_ang) : AFW'(cor_ang);
	assign ang_rnd = ang_full + lpia_pkg::ANG_ROUND;

	// output word
	always_ff @(posedge clk) begin
		if (en) begin
			cr_s62 <= cr_cl_s[CL-1];
			cx_s62 <= cr_cl_s[CL-1] ? cx_cl_s[CL-1] : '0;
			cy_s62 <= cr_cl_s[CL-1] ? cy_cl_s[CL-1] : '0;
			av_s62 <= av_cl_s[CL-1];
			ang_s62 <= av_cl_s[CL-1] ?
				ang_rnd[lpia_pkg::ANG_ROUND_SH +: lpia_pkg::ANG_OUT_W] : '0;
		end
	end

	assign out_valid = vld_s62;
	assign crosses = cr_s62;
	assign cross_x = cx_s62;
	assign cross_y = cy_s62;
	assign angle_deg = ang_s62;
	assign angle_valid = av_s62;

endmodule
